>>> hdl/spms_pkg.sv
// Types and constants shared by the shared-pool multi-stack unit and its checker.
package spms_pkg;

	localparam int CAPACITY   = 16;
	localparam int NUM_STACKS = 4;
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int ID_W       = 2;
	localparam int DATA_W     = 32;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_PEEK = 2'd2,
		ACT_NOP  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		action_t            action;
		logic [ID_W-1:0]    stack_id;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		status_t            status;
		logic               stack_empty;
		logic               pool_full;
	} rsp_t;

endpackage

>>> hdl/shared_pool_multi_stack_unit.sv
// Several LIFO stacks sharing one slot pool managed by a free-slot stack.
//
// Usage: a transaction (push, pop or peek on one stack) is taken at every rising
// clock edge where start is high and busy is low. Busy is set only by reset and
// is cleared by the clock once reset releases, so after that one transaction can be
// issued every cycle. Each transaction yields exactly one result on rsp, shown for
// one cycle with done high, after it is taken: first it sits in the input
// register, then one pass of logic over the top pointers, the free-slot stack and
// the slot store into the result register. The receiver cannot stall, so results
// must be captured in the cycle done is high. Back-to-back transactions see each
// other's effects in order, because the state is updated in the same edge that
// loads the result register. A push into a full pool reports overflow and changes
// nothing; a pop or peek on an empty stack reports underflow with read_value -1.
module shared_pool_multi_stack_unit
	import spms_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	// Input register stage.
	logic valid_s1;
	req_t item_s1;

	// Result register.
	logic done_q;
	rsp_t rsp_q;

	// Set by reset and cleared by the clock once reset releases, so nothing is
	// taken while the state is still coming out of reset.
	logic busy_q;

	// Per-stack top pointers; the valid bit marks a non-empty stack.
	logic [SLOT_W-1:0] top_slot_q  [NUM_STACKS];
	logic              top_valid_q [NUM_STACKS];

	// Slot store: value and link to the slot below. Every slot is written by a
	// push before any pop or peek can reach it, so these need no reset.
	logic [DATA_W-1:0] slot_value_q [CAPACITY];
	logic [SLOT_W-1:0] link_slot_q  [CAPACITY];
	logic              link_valid_q [CAPACITY];

	// Free-slot stack; the next slot handed out sits at free_count - 1.
	logic [SLOT_W-1:0] free_slots_q [CAPACITY];
	logic [CNT_W-1:0]  free_count_q;

	logic              accept;
	logic              in_range;
	logic              cur_valid;
	logic [SLOT_W-1:0] cur_slot;
	logic [CNT_W-1:0]  cnt_m1;
	logic [SLOT_W-1:0] new_slot;
	logic              pool_empty;
	logic              has_room;
	logic              do_push;
	logic              do_pop;
	rsp_t              rsp_d;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

	// Current state of the addressed stack and of the pool.
	assign in_range   = int'(item_s1.stack_id) < NUM_STACKS;
	assign cur_valid  = in_range && top_valid_q[item_s1.stack_id];
	assign cur_slot   = top_slot_q[item_s1.stack_id];
	assign cnt_m1     = free_count_q - 1'b1;
	assign new_slot   = free_slots_q[cnt_m1[SLOT_W-1:0]];
	assign pool_empty = (free_count_q == '0);
	assign has_room   = (free_count_q < CNT_W'(CAPACITY));

	assign do_push = valid_s1 && (item_s1.action == ACT_PUSH) && in_range && !pool_empty;
	assign do_pop  = valid_s1 && (item_s1.action == ACT_POP) && cur_valid && has_room;

	// Result for the item in the input register, flags taken after the operation.
	always_comb begin
		rsp_d             = '0;
		rsp_d.status      = ST_OK;
		rsp_d.stack_empty = !cur_valid;
		rsp_d.pool_full   = pool_empty;
		unique case (item_s1.action)
			ACT_PUSH: begin
				if (!in_range || pool_empty) begin
					rsp_d.status = ST_OVERFLOW;
				end else begin
					rsp_d.stack_empty = 1'b0;
					rsp_d.pool_full   = (free_count_q == CNT_W'(1));
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (!cur_valid) begin
					rsp_d.status     = ST_UNDERFLOW;
					rsp_d.read_value = -32'sd1;
				end else begin
					rsp_d.read_value = slot_value_q[cur_slot];
					if (item_s1.action == ACT_POP && has_room) begin
						rsp_d.stack_empty = !link_valid_q[cur_slot];
						rsp_d.pool_full   = 1'b0;
					end
				end
			end
			ACT_NOP: begin
				rsp_d.status = ST_OK;
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
	end

	// Top pointers, free count and free-slot stack carry reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				top_slot_q[i]  <= '0;
				top_valid_q[i] <= 1'b0;
			end
			for (int i = 0; i < CAPACITY; i++) begin
				free_slots_q[i] <= SLOT_W'(i);
			end
			free_count_q <= CNT_W'(CAPACITY);
		end else begin
			if (do_push) begin
				top_slot_q[item_s1.stack_id]  <= new_slot;
				top_valid_q[item_s1.stack_id] <= 1'b1;
				free_count_q                  <= cnt_m1;
			end else if (do_pop) begin
				top_slot_q[item_s1.stack_id]              <= link_slot_q[cur_slot];
				top_valid_q[item_s1.stack_id]             <= link_valid_q[cur_slot];
				free_slots_q[free_count_q[SLOT_W-1:0]]    <= cur_slot;
				free_count_q                              <= free_count_q + 1'b1;
			end
		end
	end

	// Slot store is written only by a successful push.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_value_q[new_slot] <= item_s1.push_value;
			link_slot_q[new_slot]  <= cur_slot;
			link_valid_q[new_slot] <= cur_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> hdl/spms_checker.sv
// Port-level checker for the shared-pool multi-stack unit, with its bind.
module spms_checker
	import spms_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// Every accepted transaction is followed by its result on done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted transaction produced no result");

	// No result appears without an earlier accepted transaction.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a transaction");

	// Underflow always reports the value -1.
	a_underflow_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_UNDERFLOW) |-> (rsp.read_value == -32'sd1))
		else $error("underflow with wrong value");

	// A successful push leaves its stack non-empty.
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(req.action, 2) == ACT_PUSH && rsp.status == ST_OK)
		|-> !rsp.stack_empty)
		else $error("stack empty after successful push");

	// Overflow happens only on a push.
	a_overflow_push: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_OVERFLOW) |-> ($past(req.action, 2) == ACT_PUSH))
		else $error("overflow on an action other than push");

endmodule

bind shared_pool_multi_stack_unit spms_checker u_spms_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
